### rtl/core/nirfd_pkg.sv
package nirfd_pkg;

   // Field widths
   localparam int unsigned HIGH_TIME_W = 14;
   localparam int unsigned KEY_W       = 8;
   localparam int unsigned REPEAT_W    = 8;
   localparam int unsigned TICK_W      = 4;
   localparam int unsigned SHIFT_W     = 32;
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 8;

   // Event kinds on the request tuser
   typedef enum logic [1:0] {
      KIND_RISE = 2'd0,
      KIND_FALL = 2'd1,
      KIND_TICK = 2'd2,
      KIND_SCAN = 2'd3
   } nirfd_kind_type;

   // Classified operations passed from front to back
   typedef enum logic [2:0] {
      OP_RISE        = 3'd0,
      OP_FALL_NONE   = 3'd1,
      OP_FALL_ZERO   = 3'd2,
      OP_FALL_ONE    = 3'd3,
      OP_FALL_REPEAT = 3'd4,
      OP_FALL_LEADER = 3'd5,
      OP_TICK        = 3'd6,
      OP_SCAN        = 3'd7
   } nirfd_op_type;

   // Register indexes on the csr port
   localparam logic [CSR_INDEX_W-1:0] CSR_EXPECTED_ADDR = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TIMEOUT_TICKS = 2'd1;

   localparam logic [KEY_W-1:0]  EXPECTED_ADDR_RESET = 8'd0;
   localparam logic [TICK_W-1:0] TIMEOUT_RESET       = 4'd14;

   // Pulse windows in microseconds (open intervals)
   localparam logic [HIGH_TIME_W-1:0] ZERO_LO   = 14'd300;
   localparam logic [HIGH_TIME_W-1:0] ZERO_HI   = 14'd800;
   localparam logic [HIGH_TIME_W-1:0] ONE_LO    = 14'd1400;
   localparam logic [HIGH_TIME_W-1:0] ONE_HI    = 14'd1800;
   localparam logic [HIGH_TIME_W-1:0] REPEAT_LO = 14'd2200;
   localparam logic [HIGH_TIME_W-1:0] REPEAT_HI = 14'd2600;
   localparam logic [HIGH_TIME_W-1:0] LEADER_LO = 14'd4200;
   localparam logic [HIGH_TIME_W-1:0] LEADER_HI = 14'd4700;

   // Queue status seen by the top level
   typedef struct packed {
      logic full;
      logic empty;
   } nirfd_qstat_type;

endpackage

### rtl/core/nec_ir_frame_decoder_unit.sv
// Channel   Ports          Direction  Contents
// req       req_t*         in         tuser: kind[1:0]; tdata: high_time_us[13:0]
// rsp       rsp_t*         out        tdata: key_code, repeat_count, frame_ready,
//                                     leader_active
// csr       csr_*          in         index 0 expected address, index 1 timeout_ticks
//
// One event per clock sustained while rsp_tready stays high. An accepted event
// is classified and queued, then applied to the decoder state at the queue head
// once the result register is free; that register then offers the result on rsp.
// Latency and throughput are set by the op queue and the single result register.
// Reset is synchronous; no clearing pass.
// A stalled rsp side fills the queue, after which req_tready drops.
module nec_ir_frame_decoder_unit #(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [15:0]                          req_tdata,  // [13:0] high_time_us
   input  logic [1:0]                           req_tuser,  // [1:0] kind
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [7:0] key_code, [15:8] repeat_count, [16] frame_ready, [17] leader_active
   output logic [23:0]                          rsp_tdata,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [nirfd_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [nirfd_pkg::CSR_DATA_W-1:0]     csr_data
);
   import nirfd_pkg::*;

   logic            push;
   logic            pop;
   nirfd_op_type    push_op;
   nirfd_op_type    head_op;
   nirfd_qstat_type qstat;

   // Event classification
   nirfd_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .queue_full (qstat.full),
      .push       (push),
      .push_op    (push_op)
   );

   // Op queue between front and back
   nirfd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .push_op (push_op),
      .pop     (pop),
      .head_op (head_op),
      .status  (qstat)
   );

   // Decoder state and result register
   nirfd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (qstat.empty),
      .head_op     (head_op),
      .pop         (pop),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

`ifndef SYNTHESIS
   a_queue_state: assert property (@(posedge clock) disable iff (reset)
      !(qstat.full && qstat.empty))
      else $error("queue reports full and empty together");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !qstat.empty)
      else $error("back popped an empty queue");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push |-> !qstat.full)
      else $error("front pushed into a full queue");

   a_key_keeps_frame: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[7:0] != 8'd0 && rsp_tdata[17]) |-> rsp_tdata[16])
      else $error("valid key with leader held but frame dropped");
`endif

endmodule

### rtl/core/nirfd_front.sv
module nirfd_front (
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [15:0]                    req_tdata,
   input  logic [1:0]                     req_tuser,
   input  logic                           queue_full,
   output logic                           push,
   output nirfd_pkg::nirfd_op_type        push_op
);
   import nirfd_pkg::*;

   logic [HIGH_TIME_W-1:0] high_time;
   nirfd_kind_type         kind;

   assign high_time  = req_tdata[HIGH_TIME_W-1:0];
   assign kind       = nirfd_kind_type'(req_tuser);
   assign req_tready = !queue_full;
   assign push       = req_tvalid && !queue_full;

   // Map each event to an operation; falling edges by pulse window
   always_comb begin
      push_op = OP_SCAN;
      case (kind)
         KIND_RISE: push_op = OP_RISE;
         KIND_FALL: begin
            if (high_time > ZERO_LO && high_time < ZERO_HI) begin
               push_op = OP_FALL_ZERO;
            end else if (high_time > ONE_LO && high_time < ONE_HI) begin
               push_op = OP_FALL_ONE;
            end else if (high_time > REPEAT_LO && high_time < REPEAT_HI) begin
               push_op = OP_FALL_REPEAT;
            end else if (high_time > LEADER_LO && high_time < LEADER_HI) begin
               push_op = OP_FALL_LEADER;
            end else begin
               push_op = OP_FALL_NONE;
            end
         end
         KIND_TICK: push_op = OP_TICK;
         KIND_SCAN: push_op = OP_SCAN;
         default:   push_op = OP_SCAN;
      endcase
   end

endmodule

### rtl/core/nirfd_queue.sv
module nirfd_queue #(
   parameter int unsigned DEPTH = 2
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  nirfd_pkg::nirfd_op_type       push_op,
   input  logic                          pop,
   output nirfd_pkg::nirfd_op_type       head_op,
   output nirfd_pkg::nirfd_qstat_type    status
);
   import nirfd_pkg::*;

   localparam int unsigned IDX_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   nirfd_op_type      entry_ff [DEPTH];
   logic [IDX_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [IDX_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign head_op      = entry_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

### rtl/core/nirfd_back.sv
module nirfd_back (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  queue_empty,
   input  nirfd_pkg::nirfd_op_type               head_op,
   output logic                                  pop,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [nirfd_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [nirfd_pkg::CSR_DATA_W-1:0]      csr_data,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [23:0]                           rsp_tdata
);
   import nirfd_pkg::*;

   // Configuration
   logic [KEY_W-1:0]    expected_addr_ff;
   logic [TICK_W-1:0]   timeout_ff;

   // Decoder state
   logic                leader_ff, leader_in;
   logic                frame_ff, frame_in;
   logic                armed_ff, armed_in;
   logic [TICK_W-1:0]   tick_ff, tick_in;
   logic [SHIFT_W-1:0]  shift_ff, shift_in;
   logic [REPEAT_W-1:0] repeats_ff, repeats_in;

   // Result register
   logic                rsp_valid_ff;
   logic [KEY_W-1:0]    key_ff, key_in;

   logic [7:0] addr_b, naddr_b, cmd_b, ncmd_b;

   assign csr_ready  = 1'b1;
   assign pop        = !queue_empty && (!rsp_valid_ff || rsp_tready);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, leader_ff, frame_ff, repeats_ff, key_ff};

   assign addr_b  = shift_ff[31:24];
   assign naddr_b = shift_ff[23:16];
   assign cmd_b   = shift_ff[15:8];
   assign ncmd_b  = shift_ff[7:0];

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         expected_addr_ff <= EXPECTED_ADDR_RESET;
         timeout_ff       <= TIMEOUT_RESET;
      end else if (csr_valid) begin
         if (csr_index == CSR_EXPECTED_ADDR) begin
            expected_addr_ff <= csr_data;
         end else if (csr_index == CSR_TIMEOUT_TICKS) begin
            timeout_ff <= csr_data[TICK_W-1:0];
         end
      end
   end

   // Next decoder state for the operation at the queue head
   always_comb begin
      leader_in  = leader_ff;
      frame_in   = frame_ff;
      armed_in   = armed_ff;
      tick_in    = tick_ff;
      shift_in   = shift_ff;
      repeats_in = repeats_ff;
      key_in     = '0;
      case (head_op)
         OP_RISE: armed_in = 1'b1;
         OP_FALL_NONE: armed_in = 1'b0;
         OP_FALL_ZERO: begin
            armed_in = 1'b0;
            if (armed_ff && leader_ff) begin
               shift_in = {shift_ff[SHIFT_W-2:0], 1'b0};
            end
         end
         OP_FALL_ONE: begin
            armed_in = 1'b0;
            if (armed_ff && leader_ff) begin
               shift_in = {shift_ff[SHIFT_W-2:0], 1'b1};
            end
         end
         OP_FALL_REPEAT: begin
            armed_in = 1'b0;
            if (armed_ff && leader_ff) begin
               repeats_in = repeats_ff + 1'b1;
               tick_in    = '0;
            end
         end
         OP_FALL_LEADER: begin
            armed_in = 1'b0;
            if (armed_ff && !leader_ff) begin
               leader_in  = 1'b1;
               repeats_in = '0;
            end
         end
         OP_TICK: begin
            if (leader_ff) begin
               armed_in = 1'b0;
               if (tick_ff == '0) begin
                  frame_in = 1'b1;
               end
               if (tick_ff < timeout_ff) begin
                  tick_in = tick_ff + 1'b1;
               end else begin
                  leader_in = 1'b0;
                  tick_in   = '0;
               end
            end
         end
         OP_SCAN: begin
            if (frame_ff) begin
               if (addr_b == ~naddr_b && addr_b == expected_addr_ff &&
                   cmd_b == ~ncmd_b) begin
                  key_in = cmd_b;
               end
               // zero command, bad frame or lost leader clears the frame
               if (key_in == '0 || !leader_ff) begin
                  frame_in   = 1'b0;
                  repeats_in = '0;
               end
            end
         end
         default: key_in = '0;
      endcase
   end

   // State and result registers advance on each pop
   always_ff @(posedge clock) begin
      if (reset) begin
         leader_ff    <= 1'b0;
         frame_ff     <= 1'b0;
         armed_ff     <= 1'b0;
         tick_ff      <= '0;
         shift_ff     <= '0;
         repeats_ff   <= '0;
         key_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            leader_ff  <= leader_in;
            frame_ff   <= frame_in;
            armed_ff   <= armed_in;
            tick_ff    <= tick_in;
            shift_ff   <= shift_in;
            repeats_ff <= repeats_in;
            key_ff     <= key_in;
         end
         if (pop) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

endmodule

### tb/ir_frame_check_pkg.sv
package ir_frame_check_pkg;
   import nirfd_pkg::*;

   // One decoder status transfer, field by field
   typedef struct {
      logic [KEY_W-1:0]    key_code;
      logic [REPEAT_W-1:0] repeat_count;
      logic                frame_ready;
      logic                leader_active;
   } ir_status_type;

   class ir_frame_scoreboard;
      // register copies
      logic [CSR_DATA_W-1:0] expected_addr;
      logic [TICK_W-1:0]     timeout_ticks;
      // decoder state copy
      logic                  leader_seen;
      logic                  frame_complete;
      logic                  rising_armed;
      logic [TICK_W-1:0]     tick_count;
      logic [SHIFT_W-1:0]    shift_bits;
      logic [REPEAT_W-1:0]   repeat_total;
      // statuses still owed by the block, oldest first
      ir_status_type         owed_status[$];
      int                    errors;
      int                    checked;
      int                    keys_returned;
      int                    leader_drops;

      function new();
         expected_addr  = EXPECTED_ADDR_RESET;
         timeout_ticks  = TIMEOUT_RESET;
         leader_seen    = 1'b0;
         frame_complete = 1'b0;
         rising_armed   = 1'b0;
         tick_count     = '0;
         shift_bits     = '0;
         repeat_total   = '0;
         errors         = 0;
         checked        = 0;
         keys_returned  = 0;
         leader_drops   = 0;
      endfunction

      function void set_register(logic [CSR_INDEX_W-1:0] index,
                                 logic [CSR_DATA_W-1:0] value);
         case (index)
            CSR_EXPECTED_ADDR: expected_addr = value;
            CSR_TIMEOUT_TICKS: timeout_ticks = value[TICK_W-1:0];
            default: ;
         endcase
      endfunction

      // Apply one accepted event and queue the status it leaves behind
      function void note_event(nirfd_kind_type kind, logic [HIGH_TIME_W-1:0] t);
         ir_status_type status;
         logic [7:0] addr, addr_n, cmd, cmd_n;
         logic [KEY_W-1:0] key;
         key = '0;
         case (kind)
            KIND_RISE: rising_armed = 1'b1;
            KIND_FALL: begin
               if (rising_armed) begin
                  if (leader_seen) begin
                     if (t > ZERO_LO && t < ZERO_HI)
                        shift_bits = {shift_bits[SHIFT_W-2:0], 1'b0};
                     else if (t > ONE_LO && t < ONE_HI)
                        shift_bits = {shift_bits[SHIFT_W-2:0], 1'b1};
                     else if (t > REPEAT_LO && t < REPEAT_HI) begin
                        repeat_total = repeat_total + 1'b1;
                        tick_count   = '0;
                     end
                  end else if (t > LEADER_LO && t < LEADER_HI) begin
                     leader_seen  = 1'b1;
                     repeat_total = '0;
                  end
               end
               rising_armed = 1'b0;
            end
            KIND_TICK: begin
               if (leader_seen) begin
                  rising_armed = 1'b0;
                  if (tick_count == 0)
                     frame_complete = 1'b1;
                  if (tick_count < timeout_ticks)
                     tick_count = tick_count + 1'b1;
                  else begin
                     leader_seen = 1'b0;
                     tick_count  = '0;
                     leader_drops++;
                  end
               end
            end
            default: begin
               if (frame_complete) begin
                  {addr, addr_n, cmd, cmd_n} = shift_bits;
                  if ((addr ^ addr_n) == 8'hFF && addr == expected_addr &&
                      (cmd ^ cmd_n) == 8'hFF)
                     key = cmd;
                  // bad frame, zero command or lost leader clears the frame
                  if (key == 0 || !leader_seen) begin
                     frame_complete = 1'b0;
                     repeat_total   = '0;
                  end
               end
               if (key != 0)
                  keys_returned++;
            end
         endcase
         status.key_code      = key;
         status.repeat_count  = repeat_total;
         status.frame_ready   = frame_complete;
         status.leader_active = leader_seen;
         owed_status.push_back(status);
      endfunction

      task report_mismatch(string what);
         errors++;
         if (errors <= 25)
            $display("[%0t] mismatch: %s", $time, what);
      endtask

      // Compare one rsp transfer with the oldest owed status
      task check_result(logic [23:0] data);
         ir_status_type want;
         if (owed_status.size() == 0) begin
            report_mismatch($sformatf("status %h with nothing owed", data));
            return;
         end
         want = owed_status.pop_front();
         checked++;
         if (data[7:0] !== want.key_code)
            report_mismatch($sformatf("key_code %h, want %h", data[7:0], want.key_code));
         if (data[15:8] !== want.repeat_count)
            report_mismatch($sformatf("repeat_count %h, want %h",
                                      data[15:8], want.repeat_count));
         if (data[16] !== want.frame_ready)
            report_mismatch($sformatf("frame_ready %b, want %b", data[16], want.frame_ready));
         if (data[17] !== want.leader_active)
            report_mismatch($sformatf("leader_active %b, want %b",
                                      data[17], want.leader_active));
      endtask
   endclass

endpackage

### tb/tb.sv
module tb;
   import nirfd_pkg::*;
   import ir_frame_check_pkg::*;

   localparam int EVENT_TARGET = 2000;
   localparam int QUIET_LIMIT  = 5000;
   localparam int HOLD_CYCLES  = 300;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [15:0]            req_tdata = '0;  // [13:0] high_time_us
   logic [1:0]             req_tuser = '0;  // [1:0] kind
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   // [7:0] key_code, [15:8] repeat_count, [16] frame_ready, [17] leader_active
   logic [23:0]            rsp_tdata;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   ir_frame_scoreboard sb = new();

   int idle_pct = 0;
   bit long_hold_req = 1'b0;
   int events_sent = 0;
   int frames_sent = 0;
   int csr_writes = 0;
   int quiet_cycles = 0;

   logic [HIGH_TIME_W-1:0] window_edges [8] = '{ZERO_LO, ZERO_HI, ONE_LO, ONE_HI,
                                               REPEAT_LO, REPEAT_HI, LEADER_LO, LEADER_HI};

   nec_ir_frame_decoder_unit DUT (.*);

   always #5 clock = ~clock;

   // Gap length: mostly none or short, now and then long
   function automatic int pick_gap();
      if ($urandom_range(0, 99) >= idle_pct)
         return 0;
      if ($urandom_range(0, 9) == 0)
         return $urandom_range(10, 40);
      return $urandom_range(1, 3);
   endfunction

   function automatic logic [HIGH_TIME_W-1:0] any_time();
      return HIGH_TIME_W'($urandom);
   endfunction

   // Frame word: address, its inverse, command, its inverse; sometimes spoiled
   function automatic logic [31:0] make_word(logic [7:0] id);
      logic [7:0] addr, addr_n, cmd, cmd_n;
      addr = ($urandom_range(0, 3) != 0) ? id : 8'($urandom);
      case ($urandom_range(0, 9))
         0:       cmd = 8'h00;
         1:       cmd = 8'hFF;
         default: cmd = 8'($urandom);
      endcase
      addr_n = ~addr;
      cmd_n  = ~cmd;
      if ($urandom_range(0, 7) == 0)
         addr_n ^= 8'(1 << $urandom_range(0, 7));
      if ($urandom_range(0, 7) == 0)
         cmd_n ^= 8'(1 << $urandom_range(0, 7));
      return {addr, addr_n, cmd, cmd_n};
   endfunction

   // One req transfer, then an optional gap
   task automatic send_event(nirfd_kind_type kind, logic [HIGH_TIME_W-1:0] t);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {2'b00, t};
      do @(posedge clock); while (!req_tready);
      sb.note_event(kind, t);
      events_sent++;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_pulse(logic [HIGH_TIME_W-1:0] t);
      send_event(KIND_RISE, any_time());
      send_event(KIND_FALL, t);
   endtask

   // Random kind; high time uniform or right at a window edge
   task automatic send_noise();
      nirfd_kind_type kind;
      logic [HIGH_TIME_W-1:0] t;
      kind = nirfd_kind_type'($urandom_range(0, 3));
      case ($urandom_range(0, 2))
         0:       t = any_time();
         1:       t = HIGH_TIME_W'($urandom_range(0, 10000));
         default: t = window_edges[$urandom_range(0, 7)] + HIGH_TIME_W'($urandom_range(0, 2))
                      - 1'b1;
      endcase
      send_event(kind, t);
   endtask

   // Leader, data bits, ticks, repeat codes and scans as a remote sends them
   task automatic send_frame(logic [31:0] word, int n_bits, int n_repeats, int n_ticks);
      int i;
      send_pulse(HIGH_TIME_W'($urandom_range(LEADER_LO + 1, LEADER_HI - 1)));
      for (i = 0; i < n_bits; i++) begin
         if ($urandom_range(0, 39) == 0)
            send_noise();
         if (word[31 - (i % 32)])
            send_pulse(HIGH_TIME_W'($urandom_range(ONE_LO + 1, ONE_HI - 1)));
         else
            send_pulse(HIGH_TIME_W'($urandom_range(ZERO_LO + 1, ZERO_HI - 1)));
      end
      send_event(KIND_TICK, any_time());
      send_event(KIND_SCAN, any_time());
      for (i = 0; i < n_repeats; i++) begin
         send_pulse(HIGH_TIME_W'($urandom_range(REPEAT_LO + 1, REPEAT_HI - 1)));
         send_event(KIND_TICK, any_time());
         send_event(KIND_SCAN, any_time());
      end
      // run the tick counter toward the leader timeout
      for (i = 0; i < n_ticks; i++) begin
         send_event(KIND_TICK, any_time());
         if ($urandom_range(0, 2) == 0)
            send_event(KIND_SCAN, any_time());
      end
      send_event(KIND_SCAN, any_time());
      frames_sent++;
   endtask

   // Hold the sender until every owed status has come back
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (sb.owed_status.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] value);
      drain_results();
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sb.set_register(index, value);
      csr_writes++;
   endtask

   // rsp side: random stalls, plus one long hold-off on request
   initial begin : rsp_side
      int stall;
      forever begin
         @(posedge clock);
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         stall = pick_gap();
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   // Check every rsp transfer
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_result(rsp_tdata);
   end

   // Watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles", quiet_cycles);
         $display("nec_ir_frame_decoder_unit regression: fail");
         $finish;
      end
   end

   initial begin : stimulus
      int round;
      int n_bits;
      logic [7:0] id;
      logic [3:0] timeout;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // empty scan, tick with no leader, fall with no rise
      send_event(KIND_SCAN, 14'h3FFF);
      send_event(KIND_TICK, 14'h0000);
      send_event(KIND_FALL, 14'd4500);
      // leader window edges, then a real leader
      send_pulse(LEADER_LO);
      send_pulse(LEADER_HI);
      send_pulse(LEADER_LO + 1'b1);
      // bit and repeat window edges
      send_pulse(ZERO_LO);
      send_pulse(ZERO_LO + 1'b1);
      send_pulse(ONE_HI);
      send_pulse(ONE_HI - 1'b1);
      send_pulse(REPEAT_HI - 1'b1);
      // double rise, then full-scale high time
      send_event(KIND_RISE, 14'h2AAA);
      send_pulse(14'h3FFF);
      // frame complete, scan of a bad frame
      send_event(KIND_TICK, 14'h1555);
      send_event(KIND_SCAN, 14'h0000);
      drain_results();

      round = 0;
      while (events_sent < EVENT_TARGET) begin
         // new register settings every third frame; extremes first
         if (frames_sent % 3 == 0) begin
            case (round)
               0:       begin id = 8'hFF; timeout = 4'd1;  end
               1:       begin id = 8'h00; timeout = 4'd15; end
               2:       begin id = 8'($urandom); timeout = 4'd0; end
               default: begin id = 8'($urandom); timeout = 4'($urandom_range(1, 15)); end
            endcase
            write_csr(CSR_EXPECTED_ADDR, id);
            write_csr(CSR_TIMEOUT_TICKS, {4'b0000, timeout});
            round++;
         end

         case ($urandom_range(0, 3))
            0:       idle_pct = 0;
            1:       idle_pct = 10;
            2:       idle_pct = 30;
            default: idle_pct = 60;
         endcase

         // once: drain, then long rsp hold-off under a back-to-back frame
         if (frames_sent == 4) begin
            drain_results();
            idle_pct = 0;
            long_hold_req = 1'b1;
         end

         if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(3, 15)) send_noise();
         n_bits = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : 32;
         send_frame(make_word(sb.expected_addr), n_bits, $urandom_range(0, 3),
                    $urandom_range(0, 18));
      end

      drain_results();
      repeat (10) @(posedge clock);
      $display("sent %0d events in %0d frames plus noise, %0d register writes",
               events_sent, frames_sent, csr_writes);
      $display("checked %0d statuses: %0d valid keys, %0d leader timeouts",
               sb.checked, sb.keys_returned, sb.leader_drops);
      if (sb.errors == 0 && sb.owed_status.size() == 0)
         $display("nec_ir_frame_decoder_unit regression: pass");
      else
         $display("nec_ir_frame_decoder_unit regression: fail");
      $finish;
   end

endmodule
